/* rtl/assert_macros.svh */
// assertion macros shared by the mixer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ACM_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ACM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the cycle after
`define ACM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/acm_pkg.sv */
// shared types, register indexes and rounding helper for the audio channel mixer
// no dependencies
package acm_pkg;

  localparam int unsigned MAX_CH      = 4;
  localparam int unsigned CONTRIB_W   = 21;
  localparam int unsigned SUM_W       = 23;
  localparam int unsigned MIX_W       = 28;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_VOLUMES = 3'd1;
  localparam logic [2:0] REG_PANS    = 3'd2;
  localparam logic [2:0] REG_LENGTHS = 3'd3;
  localparam logic [2:0] REG_MASTER  = 3'd4;
  localparam logic [2:0] REG_STEREO  = 3'd5;

  typedef logic signed [CONTRIB_W-1:0] contrib_t;
  typedef logic signed [MIX_W-1:0] mix_t;

  // signed shift right with rounding half away from zero
  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned n);
    logic [63:0] m;
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return v[63] ? $signed(64'd0 - m) : $signed(m);
  endfunction

endpackage

/* rtl/acm_lane.sv */
// one channel lane: volume scaling and constant-power pan gains
// depends on acm_pkg
module acm_lane #(
  parameter int unsigned GAIN_TABLE_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic              use_i,
  input  logic              stereo_i,
  input  logic signed [15:0] sample_i,
  input  logic [15:0]       volume_i,
  input  logic [15:0]       pan_i,
  output acm_pkg::contrib_t contrib_l_o,
  output acm_pkg::contrib_t contrib_r_o
);

  localparam int unsigned KW = $clog2(GAIN_TABLE_SIZE);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] GAIN_DEN = (GAIN_TABLE_SIZE > 1) ? 64'(GAIN_TABLE_SIZE - 1) : 64'd1;

  typedef logic [16:0] gain_rom_t [GAIN_TABLE_SIZE];

  function automatic logic [16:0] sine_q15(logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = k * HALF_PI_Q30 / GAIN_DEN;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      sum  = (n % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    return (sum > 64'sd32768) ? 17'd32768 : 17'(sum);
  endfunction

  function automatic gain_rom_t build_rom();
    gain_rom_t r;
    for (int k = 0; k < GAIN_TABLE_SIZE; k++) r[k] = sine_q15(64'(k));
    return r;
  endfunction

  localparam gain_rom_t GAIN_ROM = build_rom();

  logic signed [15:0] pan_c;
  logic [15:0]        pan_off;
  logic [31:0]        k_full;
  logic [KW-1:0]      k_idx;
  logic [KW-1:0]      k_mir;

  logic signed [32:0] prod_q;
  logic [16:0]        gain_l_q, gain_r_q;
  logic signed [50:0] pl_q, pr_q;
  acm_pkg::contrib_t  cl_q, cr_q;

  always_comb begin
    pan_c = $signed(pan_i);
    if (pan_c < -16'sd16384) pan_c = -16'sd16384;
    if (pan_c > 16'sd16384)  pan_c = 16'sd16384;
    pan_off = 16'(pan_c + 16'sd16384);
    k_full  = (32'(pan_off) * 32'(GAIN_TABLE_SIZE - 1) + 32'd16384) >> 15;
    k_idx   = k_full[KW-1:0];
    k_mir   = KW'(GAIN_TABLE_SIZE - 1) - k_idx;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q   <= use_i ? 33'($signed(sample_i) * $signed({1'b0, volume_i})) : '0;
      // mono runs the left path at unity gain, i.e. a plain round by 2^12
      gain_l_q <= stereo_i ? GAIN_ROM[k_mir] : 17'd32768;
      gain_r_q <= stereo_i ? GAIN_ROM[k_idx] : 17'd0;
      pl_q     <= 51'(prod_q * $signed({1'b0, gain_l_q}));
      pr_q     <= 51'(prod_q * $signed({1'b0, gain_r_q}));
      cl_q     <= acm_pkg::CONTRIB_W'(acm_pkg::round_shift(64'(pl_q), 27));
      cr_q     <= acm_pkg::CONTRIB_W'(acm_pkg::round_shift(64'(pr_q), 27));
    end
  end

  assign contrib_l_o = cl_q;
  assign contrib_r_o = cr_q;

endmodule

/* rtl/acm_merge.sv */
// merging stage: lane sum, master gain, soft clip with exp table
// depends on acm_pkg
module acm_merge #(
  parameter int unsigned NUM_CHANNELS    = 4,
  parameter int unsigned CLIP_TABLE_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [15:0]       master_i,
  input  acm_pkg::contrib_t contrib_l_i [NUM_CHANNELS],
  input  acm_pkg::contrib_t contrib_r_i [NUM_CHANNELS],
  output logic [15:0]       left_o,
  output logic [15:0]       right_o
);

  localparam int unsigned JW = $clog2(CLIP_TABLE_SIZE);
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef logic [15:0] exp_rom_t [CLIP_TABLE_SIZE];

  function automatic logic [15:0] exp_q15(logic [63:0] j);
    logic [63:0]        a;
    logic [63:0]        y;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    a    = ONE_Q30 + (j << 34) / 64'(CLIP_TABLE_SIZE);
    y    = a >> 4;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum  = (n % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = 64'(sum);
    for (int n = 0; n < 4; n++) r = (r * r + (64'd1 << 29)) >> 30;
    return 16'((r + 64'd16384) >> 15);
  endfunction

  function automatic exp_rom_t build_rom();
    exp_rom_t t;
    for (int j = 0; j < CLIP_TABLE_SIZE; j++) t[j] = exp_q15(64'(j));
    return t;
  endfunction

  localparam exp_rom_t EXP_ROM = build_rom();

  function automatic logic [15:0] clip_q15(acm_pkg::mix_t x);
    logic [acm_pkg::MIX_W-1:0] mag;
    logic [acm_pkg::MIX_W-1:0] u;
    logic [31:0]               jf;
    logic [16:0]               e;
    logic signed [acm_pkg::MIX_W:0] yv;
    mag = x[acm_pkg::MIX_W-1] ? (acm_pkg::MIX_W)'(-x) : x;
    u   = mag - acm_pkg::MIX_W'(32768);
    jf  = (32'(u[18:0]) * 32'(CLIP_TABLE_SIZE)) >> 19;
    e   = (u >= acm_pkg::MIX_W'(1 << 19)) ? 17'd0 : 17'(EXP_ROM[jf[JW-1:0]]);
    yv  = (acm_pkg::MIX_W + 1)'(x);
    if (x > acm_pkg::MIX_W'(32768))
      yv = (acm_pkg::MIX_W + 1)'(32768) - $signed({1'b0, e});
    else if (x < -(acm_pkg::MIX_W)'(32768))
      yv = -(acm_pkg::MIX_W + 1)'(32768) + $signed({1'b0, e});
    if (yv > (acm_pkg::MIX_W + 1)'(32767))  yv = (acm_pkg::MIX_W + 1)'(32767);
    if (yv < -(acm_pkg::MIX_W + 1)'(32768)) yv = -(acm_pkg::MIX_W + 1)'(32768);
    return yv[15:0];
  endfunction

  logic signed [acm_pkg::SUM_W-1:0] sum_l_d, sum_r_d;
  logic signed [acm_pkg::SUM_W-1:0] sum_l_q, sum_r_q;
  logic signed [39:0]               gl_q, gr_q;
  acm_pkg::mix_t                    x_l_q, x_r_q;

  always_comb begin
    sum_l_d = '0;
    sum_r_d = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sum_l_d = sum_l_d + acm_pkg::SUM_W'(contrib_l_i[i]);
      sum_r_d = sum_r_d + acm_pkg::SUM_W'(contrib_r_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
      gl_q    <= 40'(sum_l_q * $signed({1'b0, master_i}));
      gr_q    <= 40'(sum_r_q * $signed({1'b0, master_i}));
      x_l_q   <= acm_pkg::MIX_W'(acm_pkg::round_shift(64'(gl_q), 12));
      x_r_q   <= acm_pkg::MIX_W'(acm_pkg::round_shift(64'(gr_q), 12));
    end
  end

  assign left_o  = clip_q15(x_l_q);
  assign right_o = clip_q15(x_r_q);

endmodule

/* rtl/audio_channel_mixer.sv */
// audio channel mixer top: frame gating, play state, lanes, merge, output register
// a frame transaction passes the seven-stage datapath and then the output register before result valid
// one frame is in the datapath at a time; a new frame is taken only once the datapath is empty
// reset clears play positions, finished flags and the frame tracker, and sets config registers to power-on values
module audio_channel_mixer #(
  parameter int unsigned NUM_CHANNELS    = 4,
  parameter int unsigned GAIN_TABLE_SIZE = 64,
  parameter int unsigned CLIP_TABLE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_ch0_i,
  input  logic [15:0] sample_ch1_i,
  input  logic [15:0] sample_ch2_i,
  input  logic [15:0] sample_ch3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_out_o,
  output logic [15:0] right_out_o,
  output logic [3:0]  playing_mask_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned STAGES = 7;
  localparam logic [3:0] CH_MASK = 4'((1 << NUM_CHANNELS) - 1);

  logic [15:0] ctrl_q;
  logic [63:0] vol_q, pan_q, len_q;
  logic [15:0] master_q;
  logic        stereo_q;

  logic [3:0][15:0] pos_q, pos_d;
  logic [3:0]       fin_q, fin_d;
  logic [3:0]       use_d, use_q;
  logic [3:0]       mask_q;
  logic [15:0]      samp_q [4];
  logic [STAGES-1:0] pipe_q;

  logic        accept, adv, cfg_wr;
  logic [3:0]  live, rise;
  logic        solo_any;

  logic        out_valid_q;
  logic [15:0] left_q, right_q;
  logic [3:0]  pmask_q;
  logic [15:0] mix_l, mix_r;

  acm_pkg::contrib_t cl [NUM_CHANNELS];
  acm_pkg::contrib_t cr [NUM_CHANNELS];

  // configuration waits for an empty datapath and holds off frame transactions
  assign cfg_ready_o = (pipe_q == '0);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (|pipe_q) || cfg_valid_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign adv         = !(pipe_q[STAGES-1] && out_valid_q && out_stall_i);

  always_comb begin
    live     = ctrl_q[3:0] & CH_MASK & ~fin_q;
    solo_any = |(live & ctrl_q[15:12]);
    rise     = cfg_data_i[3:0] & ~ctrl_q[3:0];
    pos_d    = pos_q;
    fin_d    = fin_q;
    use_d    = '0;
    if (cfg_wr && cfg_index_i == acm_pkg::REG_CONTROL) begin
      // enable rising edge restarts the channel
      for (int i = 0; i < 4; i++) begin
        if (rise[i]) begin
          pos_d[i] = '0;
          fin_d[i] = 1'b0;
        end
      end
    end else if (accept) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (live[i] && !ctrl_q[8+i] && (!solo_any || ctrl_q[12+i])) begin
          if (pos_q[i] < len_q[16*i +: 16]) begin
            pos_d[i] = pos_q[i] + 16'd1;
            use_d[i] = 1'b1;
          end else if (ctrl_q[4+i]) begin
            pos_d[i] = 16'd1;
            use_d[i] = 1'b1;
          end else begin
            fin_d[i] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      vol_q    <= 64'h1000_1000_1000_1000;
      pan_q    <= '0;
      len_q    <= '0;
      master_q <= 16'd4096;
      stereo_q <= 1'b1;
      pos_q    <= '0;
      fin_q    <= '0;
      pipe_q   <= '0;
    end else begin
      pos_q <= pos_d;
      fin_q <= fin_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          acm_pkg::REG_CONTROL: ctrl_q   <= cfg_data_i[15:0];
          acm_pkg::REG_VOLUMES: vol_q    <= cfg_data_i;
          acm_pkg::REG_PANS:    pan_q    <= cfg_data_i;
          acm_pkg::REG_LENGTHS: len_q    <= cfg_data_i;
          acm_pkg::REG_MASTER:  master_q <= cfg_data_i[15:0];
          acm_pkg::REG_STEREO:  stereo_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) pipe_q <= STAGES'(1);
      else if (adv) pipe_q <= pipe_q << 1;
    end
  end

  // frame payload, held while the frame is in the datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q[0] <= sample_ch0_i;
      samp_q[1] <= sample_ch1_i;
      samp_q[2] <= sample_ch2_i;
      samp_q[3] <= sample_ch3_i;
      use_q     <= use_d;
      mask_q    <= ctrl_q[3:0] & CH_MASK & ~fin_d;
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    acm_lane #(
      .GAIN_TABLE_SIZE(GAIN_TABLE_SIZE)
    ) u_lane (
      .clk_i      (clk_i),
      .adv_i      (adv),
      .use_i      (use_q[g]),
      .stereo_i   (stereo_q),
      .sample_i   ($signed(samp_q[g])),
      .volume_i   (vol_q[16*g +: 16]),
      .pan_i      (pan_q[16*g +: 16]),
      .contrib_l_o(cl[g]),
      .contrib_r_o(cr[g])
    );
  end

  acm_merge #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .CLIP_TABLE_SIZE(CLIP_TABLE_SIZE)
  ) u_merge (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .master_i   (master_q),
    .contrib_l_i(cl),
    .contrib_r_i(cr),
    .left_o     (mix_l),
    .right_o    (mix_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_q[STAGES-1] && adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_q[STAGES-1] && adv) begin
      left_q  <= mix_l;
      right_q <= stereo_q ? mix_r : 16'd0;
      pmask_q <= mask_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = left_q;
  assign right_out_o    = right_q;
  assign playing_mask_o = pmask_q;

  `ACM_ASSERT(a_one_frame_in_flight, $onehot0(pipe_q))
  `ACM_ASSERT_IMPL(a_accept_only_when_empty, accept, pipe_q == '0)
  `ACM_ASSERT_NEXT(a_stalled_result_kept, out_valid_q && out_stall_i, out_valid_q)

endmodule

/* tb/tb_audio_channel_mixer.sv */
// testbench for audio_channel_mixer: random and directed frames, checked against
// a bit-accurate mix predictor; depends on rtl/acm_pkg.sv and rtl/audio_channel_mixer.sv
`timescale 1ns / 100ps

typedef struct {
  logic [15:0] left;
  logic [15:0] right;
  logic [3:0]  mask;
} mix_result_t;

class mix_scoreboard;
  logic [15:0] ctl_reg;
  logic [63:0] vol_reg;
  logic [63:0] pan_reg;
  logic [63:0] len_reg;
  logic [15:0] master_reg;
  logic        stereo_reg;
  logic [15:0] position [4];
  logic [3:0]  done_flags;
  longint      pan_gain [64];
  longint      clip_exp [256];
  mix_result_t expected_mix [$];
  int          errors;

  function new();
    longint unsigned x, x2, term, a, y, r;
    longint sum;
    for (int k = 0; k < 64; k++) begin
      x = longint'(k) * 64'd1686629713 / 64'd63;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        sum += (n % 2 == 1) ? -longint'(term) : longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      pan_gain[k] = (sum > 32768) ? 32768 : sum;
    end
    for (int j = 0; j < 256; j++) begin
      a = 64'd1073741824 + (longint'(j) << 34) / 64'd256;
      y = a >> 4;
      term = 64'd1073741824;
      sum = 1073741824;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * y) >> 30) / longint'(n);
        sum += (n % 2 == 1) ? -longint'(term) : longint'(term);
      end
      if (sum < 0) sum = 0;
      r = longint'(sum);
      for (int n = 0; n < 4; n++) r = (r * r + (64'd1 << 29)) >> 30;
      clip_exp[j] = longint'((r + 16384) >> 15);
    end
    ctl_reg = 16'd0;
    vol_reg = 64'h1000_1000_1000_1000;
    pan_reg = 64'd0;
    len_reg = 64'd0;
    master_reg = 16'd4096;
    stereo_reg = 1'b1;
    for (int i = 0; i < 4; i++) position[i] = 16'd0;
    done_flags = 4'd0;
    errors = 0;
  endfunction

  function longint rnd_shift(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function logic [15:0] clip_q15(longint x);
    longint y, mag, u;
    y = x;
    if (x > 32768 || x < -32768) begin
      mag = (x < 0) ? -x : x;
      u = mag - 32768;
      mag = (u >= (longint'(16) << 15)) ? 0 : clip_exp[(u * 256) >>> 19];
      y = (x > 0) ? 32768 - mag : -32768 + mag;
    end
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      acm_pkg::REG_CONTROL: begin
        for (int i = 0; i < 4; i++) begin
          if (data[i] && !ctl_reg[i]) begin
            position[i] = 16'd0;
            done_flags[i] = 1'b0;
          end
        end
        ctl_reg = data[15:0];
      end
      acm_pkg::REG_VOLUMES: vol_reg = data;
      acm_pkg::REG_PANS:    pan_reg = data;
      acm_pkg::REG_LENGTHS: len_reg = data;
      acm_pkg::REG_MASTER:  master_reg = data[15:0];
      acm_pkg::REG_STEREO:  stereo_reg = data[0];
      default: ;
    endcase
  endfunction

  // one accepted frame -> one predicted mix
  function void note_frame(logic [3:0][15:0] smp);
    logic [3:0] en, lp, mu, so, live;
    logic       solo_any;
    longint     acc_l, acc_r, scaled, p, k;
    mix_result_t res;
    en = ctl_reg[3:0];
    lp = ctl_reg[7:4];
    mu = ctl_reg[11:8];
    so = ctl_reg[15:12];
    live = en & ~done_flags;
    solo_any = |(live & so);
    acc_l = 0;
    acc_r = 0;
    for (int i = 0; i < 4; i++) begin
      if (!live[i] || mu[i] || (solo_any && !so[i])) continue;
      if (position[i] < len_reg[16*i +: 16]) position[i] = position[i] + 16'd1;
      else if (lp[i]) position[i] = 16'd1;
      else begin
        done_flags[i] = 1'b1;
        continue;
      end
      scaled = longint'($signed(smp[i])) * longint'(vol_reg[16*i +: 16]);
      if (stereo_reg) begin
        p = longint'($signed(pan_reg[16*i +: 16]));
        if (p < -16384) p = -16384;
        if (p > 16384) p = 16384;
        k = ((p + 16384) * 63 + 16384) >>> 15;
        acc_l += rnd_shift(scaled * pan_gain[63 - k], 27);
        acc_r += rnd_shift(scaled * pan_gain[k], 27);
      end else begin
        acc_l += rnd_shift(scaled, 12);
      end
    end
    res.left = clip_q15(rnd_shift(acc_l * longint'(master_reg), 12));
    res.right = stereo_reg ? clip_q15(rnd_shift(acc_r * longint'(master_reg), 12)) : 16'd0;
    res.mask = en & ~done_flags;
    expected_mix.push_back(res);
  endfunction

  function void check_result(logic [15:0] left, logic [15:0] right, logic [3:0] mask);
    mix_result_t exp_r;
    if (expected_mix.size() == 0) begin
      $error("result transaction with no frame pending");
      errors++;
      return;
    end
    exp_r = expected_mix.pop_front();
    if (left !== exp_r.left) begin
      $error("left_out expected %h actual %h", exp_r.left, left);
      errors++;
    end
    if (right !== exp_r.right) begin
      $error("right_out expected %h actual %h", exp_r.right, right);
      errors++;
    end
    if (mask !== exp_r.mask) begin
      $error("playing_mask expected %h actual %h", exp_r.mask, mask);
      errors++;
    end
  endfunction
endclass

module tb_audio_channel_mixer;
  localparam logic [2:0] REG_SPARE = 3'd6;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0][15:0] frame_smp = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] left_out_o, right_out_o;
  logic [3:0]  playing_mask_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = 3'd0;
  logic [63:0] cfg_data_i = 64'd0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  mix_scoreboard sb = new();

  audio_channel_mixer u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sample_ch0_i(frame_smp[0]), .sample_ch1_i(frame_smp[1]),
    .sample_ch2_i(frame_smp[2]), .sample_ch3_i(frame_smp[3]),
    .out_valid_o, .out_stall_i, .left_out_o, .right_out_o, .playing_mask_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_audio_channel_mixer failed");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(left_out_o, right_out_o, playing_mask_o);
  end

  task automatic send_frame(logic [3:0][15:0] smp);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    frame_smp = smp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(smp);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_mix.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_packed(int sel);
    logic [63:0] v;
    for (int i = 0; i < 4; i++) begin
      case (sel)
        0: v[16*i +: 16] = 16'($urandom_range(12));
        1: v[16*i +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16384));
        default: v[16*i +: 16] = ($urandom_range(2) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(32768)) - 16'd16384;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [3:0][15:0] smp;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: all disabled, then extremes, pan ends, clip, finish, loop, mute, solo, mono
    send_frame({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    drain();
    write_reg(acm_pkg::REG_LENGTHS, 64'h0003_0002_0000_0001);
    write_reg(acm_pkg::REG_PANS, 64'h7FFF_8000_4000_C000);
    write_reg(acm_pkg::REG_CONTROL, 64'h0000_0000_0000_002F);
    write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame({4{16'h7FFF}});
    send_frame({4{16'h8000}});
    send_frame({4{16'h0000}});
    send_frame({4{16'h7FFF}});
    send_frame({16'h0001, 16'hFFFF, 16'h1234, 16'h8000});
    drain();
    write_reg(acm_pkg::REG_MASTER, 64'hFFFF);
    write_reg(acm_pkg::REG_VOLUMES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(acm_pkg::REG_CONTROL, 64'h0000_0000_0000_0000);
    write_reg(acm_pkg::REG_CONTROL, 64'h0000_0000_0000_84FF);
    send_frame({4{16'h7FFF}});
    send_frame({4{16'h8000}});
    send_frame({16'h4000, 16'h2000, 16'hC000, 16'h1000});
    write_reg(acm_pkg::REG_CONTROL, 64'h0000_0000_0000_18F7);
    send_frame({4{16'h7FFF}});
    send_frame({4{16'h8000}});
    drain();
    write_reg(acm_pkg::REG_STEREO, 64'd0);
    write_reg(acm_pkg::REG_MASTER, 64'h1000);
    send_frame({4{16'h7FFF}});
    send_frame({4{16'h8000}});
    send_frame({16'h0100, 16'hFF00, 16'h7FFF, 16'h0001});
    drain();
    write_reg(acm_pkg::REG_STEREO, 64'd1);
    write_reg(acm_pkg::REG_VOLUMES, 64'd0);
    send_frame({4{16'h7FFF}});
    drain();

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        3: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = $urandom_range(30); recv_stall_pct = $urandom_range(30); end
      endcase
      write_reg(acm_pkg::REG_VOLUMES, rand_packed(1));
      write_reg(acm_pkg::REG_PANS, rand_packed(2));
      write_reg(acm_pkg::REG_LENGTHS, ($urandom_range(5) == 0) ? {$urandom, $urandom}
                                                                : rand_packed(0));
      write_reg(acm_pkg::REG_MASTER, ($urandom_range(3) == 0) ? 64'($urandom_range(65535))
                                                              : 64'($urandom_range(8192)));
      write_reg(acm_pkg::REG_STEREO, 64'($urandom_range(3) != 0));
      write_reg(acm_pkg::REG_CONTROL, 64'($urandom_range(65535)));
      if ($urandom_range(1)) write_reg(REG_SPARE | 3'($urandom_range(1)), {$urandom, $urandom});
      write_reg(acm_pkg::REG_CONTROL, 64'($urandom_range(65535)) | 64'hF);
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_left = 400;
      end
      for (int n = 0; n < 128; n++) begin
        for (int i = 0; i < 4; i++) smp[i] = rand_sample();
        send_frame(smp);
        // re-arm some channels mid-phase
        if (n == 64 && $urandom_range(1)) begin
          drain();
          write_reg(acm_pkg::REG_CONTROL, {48'd0, sb.ctl_reg[15:4], 4'd0});
          write_reg(acm_pkg::REG_CONTROL, 64'($urandom_range(65535)));
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_mix.size() == 0) begin
      $display("tb_audio_channel_mixer passed");
    end else begin
      $display("tb_audio_channel_mixer failed");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/acm_pkg.sv
rtl/acm_lane.sv
rtl/acm_merge.sv
rtl/audio_channel_mixer.sv
tb/tb_audio_channel_mixer.sv
